// File: sv/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on a clock named clk and an active high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bdo_pkg.sv
// Shared types and constants for the brightness difference overlay.
// No dependencies; imported by every module of the block.
package bdo_pkg;

  localparam int PIX_W  = 8;
  localparam int GAIN_W = 15;

  // fixed-point luma, 14 fractional bits
  localparam int        LUMA_W     = 23;
  localparam int        LUMA_SHIFT = 14;
  localparam logic [LUMA_W-1:0] LUMA_R   = 23'd4899;
  localparam logic [LUMA_W-1:0] LUMA_G   = 23'd9617;
  localparam logic [LUMA_W-1:0] LUMA_B   = 23'd1868;
  localparam logic [LUMA_W-1:0] LUMA_RND = 23'd8192;

  // gain product: 8-bit diff times 7.8 gain
  localparam int        GPROD_W  = PIX_W + GAIN_W;
  localparam logic [GPROD_W-1:0] GAIN_RND = 23'd128;
  localparam int        GAIN_FRAC = 8;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam int               PROD_W  = 2 * PIX_W;

  // config register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_GAIN  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFS_ONLY = 1'd1;
  localparam logic [GAIN_W-1:0]    GAIN_RESET     = 15'd256;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } bgr_t;

  typedef struct packed {
    bgr_t right;
    bgr_t left;
  } pix_pair_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray_right;
    logic [PIX_W-1:0] gray_left;
  } gray_pair_t;

  typedef struct packed {
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] scaled;
    logic             left_side;
  } scaled_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  base;
    logic [PIX_W-1:0]  scaled;
    logic              left_side;
  } dim_t;

endpackage

// File: sv/bdo_luma_stage.sv
// Stage 1: converts both BGR pixels to 8-bit gray.
// Depends on bdo_pkg.
module bdo_luma_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bdo_pkg::pix_pair_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bdo_pkg::gray_pair_t out_data
);
  import bdo_pkg::*;

  logic              valid;
  gray_pair_t        data;
  logic [LUMA_W-1:0] acc_left;
  logic [LUMA_W-1:0] acc_right;

  assign acc_left  = LUMA_R * LUMA_W'(in_data.left.red)
                   + LUMA_G * LUMA_W'(in_data.left.green)
                   + LUMA_B * LUMA_W'(in_data.left.blue) + LUMA_RND;
  assign acc_right = LUMA_R * LUMA_W'(in_data.right.red)
                   + LUMA_G * LUMA_W'(in_data.right.green)
                   + LUMA_B * LUMA_W'(in_data.right.blue) + LUMA_RND;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data.gray_left  <= acc_left[LUMA_SHIFT +: PIX_W];
      data.gray_right <= acc_right[LUMA_SHIFT +: PIX_W];
    end
  end

endmodule

// File: sv/bdo_scale_stage.sv
// Stage 2: gray mean, one-sided difference and gain scaling.
// Depends on bdo_pkg.
module bdo_scale_stage (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [bdo_pkg::GAIN_W-1:0]   gain,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bdo_pkg::gray_pair_t          in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bdo_pkg::scaled_t             out_data
);
  import bdo_pkg::*;

  logic               valid;
  scaled_t            data;
  logic [PIX_W:0]     sum;
  logic               left_side;
  logic [PIX_W-1:0]   diff;
  logic [GPROD_W-1:0] gprod;
  logic [GPROD_W-GAIN_FRAC-1:0] scaled_wide;
  logic [PIX_W-1:0]   scaled_sat;

  assign sum       = {1'b0, in_data.gray_left} + {1'b0, in_data.gray_right} + 9'd1;
  assign left_side = in_data.gray_left > in_data.gray_right;
  assign diff      = left_side ? in_data.gray_left - in_data.gray_right
                               : in_data.gray_right - in_data.gray_left;
  assign gprod       = GPROD_W'(diff) * GPROD_W'(gain) + GAIN_RND;
  assign scaled_wide = gprod[GPROD_W-1:GAIN_FRAC];
  assign scaled_sat  = (scaled_wide > (GPROD_W-GAIN_FRAC)'(PIX_MAX)) ? PIX_MAX
                                                                    : scaled_wide[PIX_W-1:0];

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data.base      <= sum[PIX_W:1];
      data.scaled    <= scaled_sat;
      data.left_side <= left_side;
    end
  end

endmodule

// File: sv/bdo_dim_stage.sv
// Stage 3: product of the gray base and the inverse alpha.
// Depends on bdo_pkg.
module bdo_dim_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bdo_pkg::scaled_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output bdo_pkg::dim_t    out_data
);
  import bdo_pkg::*;

  logic             valid;
  dim_t             data;
  logic [PIX_W-1:0] inv;

  assign inv       = PIX_MAX - in_data.scaled;
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data.prod      <= PROD_W'(in_data.base) * PROD_W'(inv);
      data.base      <= in_data.base;
      data.scaled    <= in_data.scaled;
      data.left_side <= in_data.left_side;
    end
  end

endmodule

// File: sv/bdo_mix_stage.sv
// Stage 4: divide by 255, blend or replace, output register.
// Depends on bdo_pkg.
module bdo_mix_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          diffs_only,
  input  logic          in_valid,
  output logic          in_ready,
  input  bdo_pkg::dim_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output bdo_pkg::bgr_t out_data
);
  import bdo_pkg::*;

  logic              valid;
  bgr_t              data;
  bgr_t              pix;
  logic [PROD_W:0]   num;
  logic [PROD_W:0]   quo;
  logic [PIX_W-1:0]  dim;
  logic [PIX_W:0]    mark_wide;
  logic [PIX_W-1:0]  mark;

  // (2p+255)/510 == (p+127)/255; x/255 == (x + 1 + (x>>8)) >> 8 for x < 65535
  assign num       = (PROD_W+1)'(in_data.prod) + 17'd127;
  assign quo       = num + 17'd1 + (num >> PIX_W);
  assign dim       = quo[PIX_W +: PIX_W];
  assign mark_wide = {1'b0, dim} + {1'b0, in_data.scaled};
  assign mark      = mark_wide[PIX_W] ? PIX_MAX : mark_wide[PIX_W-1:0];

  always_comb begin
    pix.blue  = in_data.base;
    pix.green = in_data.base;
    pix.red   = in_data.base;
    if (in_data.scaled != '0) begin
      if (diffs_only) begin
        pix.blue  = '0;
        pix.green = in_data.left_side ? '0 : in_data.scaled;
        pix.red   = in_data.left_side ? in_data.scaled : '0;
      end else begin
        pix.blue  = dim;
        pix.green = in_data.left_side ? dim : mark;
        pix.red   = in_data.left_side ? mark : dim;
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= pix;
    end
  end

endmodule

// File: sv/brightness_diff_overlay.sv
// Brightness difference overlay: four-stage pixel pipeline with config registers.
// A pixel pair passes through four register stages (luma, scale, dim, mix) on
// its way to m_axis. Throughput: one pixel pair per clock while m_axis_tready
// is high; each stage holds one transaction and refills as soon as its
// successor takes one, so bubbles close under backpressure.
// Reset (rst, synchronous): all stage valids clear, diff_gain = 1.0, diffs_only = 0.
module brightness_diff_overlay (
  input  logic                          clk,
  input  logic                          rst,
  // pixel pair in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] left_blue, [15:8] left_green, [23:16] left_red,
  // [31:24] right_blue, [39:32] right_green, [47:40] right_red
  input  logic [47:0]                   s_axis_tdata,
  // overlay pixel out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] out_blue, [15:8] out_green, [23:16] out_red
  output logic [23:0]                   m_axis_tdata,
  // config write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bdo_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bdo_pkg::GAIN_W-1:0]    cfg_data
);
  import bdo_pkg::*;

  `include "assert_macros.svh"

  // config registers
  logic [GAIN_W-1:0] diff_gain;
  logic              diffs_only;

  // inter-stage handshakes
  logic       s1_valid, s1_ready;
  logic       s2_valid, s2_ready;
  logic       s3_valid, s3_ready;
  gray_pair_t s1_data;
  scaled_t    s2_data;
  dim_t       s3_data;
  bgr_t       out_pix;
  pix_pair_t  in_pix;

  assign in_pix       = pix_pair_t'(s_axis_tdata);
  assign m_axis_tdata = out_pix;

  // always ready; the gain is read in stage 2 and the mode in stage 4, so writes
  // are meant to come while the pipeline is empty
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_gain  <= GAIN_RESET;
      diffs_only <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIFF_GAIN:  diff_gain  <= cfg_data;
        CFG_DIFFS_ONLY: diffs_only <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // stage 1: luma of both pixels
  bdo_luma_stage u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (in_pix),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  // stage 2: mean, difference, gain multiply and saturate
  bdo_scale_stage u_scale (
    .clk       (clk),
    .rst       (rst),
    .gain      (diff_gain),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  // stage 3: base * (255 - s)
  bdo_dim_stage u_dim (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (s3_valid),
    .out_ready (s3_ready),
    .out_data  (s3_data)
  );

  // stage 4: /255, blend or pure color, output register
  bdo_mix_stage u_mix (
    .clk        (clk),
    .rst        (rst),
    .diffs_only (diffs_only),
    .in_valid   (s3_valid),
    .in_ready   (s3_ready),
    .in_data    (s3_data),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (out_pix)
  );

  // an empty output stage means every stage can take a transaction
  `ASSERT_IMPL(a_ready_when_drained, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

  // pure-color mode: blue is zero unless the pixel is gray
  `ASSERT_IMPL(a_pure_blue, m_axis_tvalid && diffs_only, (out_pix.blue == '0) || ((out_pix.blue == out_pix.green) && (out_pix.green == out_pix.red)), "blue set on marked pixel")

  // blend mode: blue is the dimmed base, shared with the unmarked channel
  `ASSERT_IMPL(a_blend_dim, m_axis_tvalid && !diffs_only, (out_pix.blue == out_pix.green) || (out_pix.blue == out_pix.red), "blend lost dimmed base")

endmodule

// File: test/testbench.sv
// Self-checking testbench for brightness_diff_overlay: directed rows, then random phases.
// Depends on bdo_pkg for the pixel types and the config register indexes.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdo_pkg::*;

  // generous bound for ~1800 transactions
  localparam int CYCLE_LIMIT = 500_000;
  localparam int PHASE_ITEMS = 200;
  localparam int FINAL_ITEMS = 180;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  pix_pair_t            s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  bgr_t                 m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_DIFF_GAIN;
  logic [GAIN_W-1:0]    cfg_data = '0;

  brightness_diff_overlay dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the config registers, updated on each config transaction
  logic [GAIN_W-1:0] cur_gain = GAIN_RESET;
  logic              cur_diffs_only = 1'b0;

  // overlay pixels still owed by the DUT, oldest first
  bgr_t pending_pixels [$];
  int   fail_count = 0;
  int   cycle_count = 0;

  // idling switches: sender gaps and receiver stalls
  bit   tx_idle = 1'b0;
  bit   rx_idle = 1'b0;
  int   stall_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // fixed-point luma, coefficients sum to 1.0 in 2.14
  function automatic int unsigned gray_of(bgr_t px);
    return (4899 * px.red + 9617 * px.green + 1868 * px.blue + 8192) >> 14;
  endfunction

  // one-sided difference times the 7.8 gain, rounded, clipped to 8 bits
  function automatic int unsigned amplify(int unsigned d, logic [GAIN_W-1:0] gain);
    int unsigned v;
    v = (d * gain + 128) >> 8;
    return (v > 255) ? 255 : v;
  endfunction

  function automatic bgr_t overlay_pixel(pix_pair_t p, logic [GAIN_W-1:0] gain, logic solid);
    int unsigned gl, gr, base, ls, rs, s, dim, mark;
    bgr_t        o;
    gl   = gray_of(p.left);
    gr   = gray_of(p.right);
    base = (gl + gr + 1) >> 1;
    ls   = amplify((gl > gr) ? gl - gr : 0, gain);
    rs   = amplify((gr > gl) ? gr - gl : 0, gain);
    o.red   = base[7:0];
    o.green = base[7:0];
    o.blue  = base[7:0];
    // at most one side is nonzero; zero on both sides leaves plain gray
    if (ls != 0 || rs != 0) begin
      s = (ls != 0) ? ls : rs;
      if (solid) begin
        o = '0;
      end else begin
        // base * (1 - s/255), rounded half up, then the marked channel adds s
        dim  = (2 * base * (255 - s) + 255) / 510;
        mark = (dim + s > 255) ? 255 : dim + s;
        o.red   = dim[7:0];
        o.green = dim[7:0];
        o.blue  = dim[7:0];
        s = mark;
      end
      if (ls != 0)
        o.red = s[7:0];
      else
        o.green = s[7:0];
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall bursts and the scoreboard
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (rx_idle && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(1, 12) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // every output transaction is matched against the oldest pending pixel
  always @(posedge clk) begin
    bgr_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected output transaction: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (m_axis_tdata.blue !== want.blue) begin
          $error("out_blue: expected %0d, got %0d", want.blue, m_axis_tdata.blue);
          fail_count++;
        end
        if (m_axis_tdata.green !== want.green) begin
          $error("out_green: expected %0d, got %0d", want.green, m_axis_tdata.green);
          fail_count++;
        end
        if (m_axis_tdata.red !== want.red) begin
          $error("out_red: expected %0d, got %0d", want.red, m_axis_tdata.red);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_pixels.size());
      $display("** brightness_diff_overlay: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // One pixel-pair transaction. The optional gap goes first, so tvalid is never
  // lowered and raised in the same time step. A typed-in result overrides the
  // predictor for the rows that can be read off by eye.
  task automatic send_pair(pix_pair_t p, bit known, bgr_t want);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tdata  <= p;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_pixels.push_back(known ? want : overlay_pixel(p, cur_gain, cur_diffs_only));
  endtask

  // Stop sending and wait until every owed pixel has come out. Always crosses
  // a clock edge first, so a following tvalid rise lands in a later step.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // config writes only while the pipeline is empty
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
    drain_results();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DIFF_GAIN)
      cur_gain = value;
    else if (idx == CFG_DIFFS_ONLY)
      cur_diffs_only = value[0];
  endtask

  task automatic apply_setting(logic [GAIN_W-1:0] gain, logic solid, bit always_write);
    if (always_write || gain != cur_gain)
      write_reg(CFG_DIFF_GAIN, gain);
    // only bit 0 counts; the upper bits carry noise
    if (always_write || solid != cur_diffs_only)
      write_reg(CFG_DIFFS_ONLY, {GAIN_W'($urandom) & 15'h7FFE} | GAIN_W'(solid));
  endtask

  // small random step on one channel, clipped to 0..255
  function automatic logic [7:0] nudge(logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Four in ten are pairs that differ by a few levels, where gain and rounding matter;
  // the rest are equal pairs, black/white corners and fully random data.
  function automatic pix_pair_t random_pair();
    pix_pair_t p;
    int        k;
    p = 48'({$urandom, $urandom});
    k = $urandom_range(0, 9);
    if (k <= 3) begin
      p.right.blue  = nudge(p.left.blue);
      p.right.green = nudge(p.left.green);
      p.right.red   = nudge(p.left.red);
    end else if (k == 4) begin
      p.right = p.left;
    end else if (k == 5) begin
      for (int i = 0; i < 48; i++)
        p[i] = p[i - (i % 8)];
      // each byte now all-zero or all-one
    end
    return p;
  endfunction

  task automatic run_phase(int n, logic [GAIN_W-1:0] gain, logic solid, int idle_mode);
    tx_idle = idle_mode[0];
    rx_idle = idle_mode[1];
    if (!rx_idle)
      stall_left = 0;
    apply_setting(gain, solid, 1'b1);
    for (int i = 0; i < n; i++) begin
      // now and then hold off until the pipeline is empty
      if ($urandom_range(0, 149) == 0)
        drain_results();
      send_pair(random_pair(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows: config, pixel pair (right RGB, left RGB) and, where it is
  // obvious, the overlay pixel (RGB). Other rows go through the predictor.
  // ---------------------------------------------------------------------------

  typedef struct {
    logic [GAIN_W-1:0] gain;
    logic              solid;
    pix_pair_t         pair;
    bit                known;
    bgr_t              want;
  } stim_row_t;

  localparam int N_DIRECTED = 22;

  stim_row_t directed_rows [N_DIRECTED] = '{
    // gain 1.0, blended
    '{15'd256,   1'b0, 48'h000000_000000, 1'b1, 24'h000000},  // black both
    '{15'd256,   1'b0, 48'hFFFFFF_FFFFFF, 1'b1, 24'hFFFFFF},  // white both
    '{15'd256,   1'b0, 48'h808080_808080, 1'b1, 24'h808080},  // equal mid gray
    '{15'd256,   1'b0, 48'h000000_FFFFFF, 1'b1, 24'hFF0000},  // left brighter, full
    '{15'd256,   1'b0, 48'hFFFFFF_000000, 1'b1, 24'h00FF00},  // right brighter, full
    '{15'd256,   1'b0, 48'h0000FF_FF0000, 1'b0, 24'h000000},  // red vs blue
    '{15'd256,   1'b0, 48'h405060_102030, 1'b0, 24'h000000},
    '{15'd256,   1'b0, 48'h414141_404040, 1'b0, 24'h000000},  // one level apart
    '{15'd256,   1'b0, 48'h00FF00_FF00FF, 1'b0, 24'h000000},
    // gain 1.0, pure color
    '{15'd256,   1'b1, 48'h000000_FFFFFF, 1'b1, 24'hFF0000},
    '{15'd256,   1'b1, 48'hFFFFFF_000000, 1'b1, 24'h00FF00},
    '{15'd256,   1'b1, 48'h646464_646464, 1'b1, 24'h646464},  // no difference stays gray
    '{15'd256,   1'b1, 48'h102030_405060, 1'b0, 24'h000000},
    // zero gain: every difference scales away
    '{15'd0,     1'b1, 48'hFFFFFF_000000, 1'b1, 24'h808080},
    '{15'd0,     1'b0, 48'h000000_FFFFFF, 1'b1, 24'h808080},
    // gains below one: a one-level step rounds to 0, then to 1
    '{15'd1,     1'b0, 48'h0B0B0B_0A0A0A, 1'b0, 24'h000000},
    '{15'd128,   1'b0, 48'h0B0B0B_0A0A0A, 1'b0, 24'h000000},
    // top of the range and the largest 15-bit gain
    '{15'd25600, 1'b0, 48'h808080_7F7F7F, 1'b0, 24'h000000},
    '{15'd25600, 1'b1, 48'h7F7F7F_808080, 1'b0, 24'h000000},
    '{15'd32767, 1'b1, 48'h0A0A0A_0B0B0B, 1'b0, 24'h000000},
    '{15'd32767, 1'b0, 48'h000000_FFFFFF, 1'b1, 24'hFF0000},
    '{15'd32767, 1'b0, 48'hC8C8C8_C9C9C9, 1'b0, 24'h000000}
  };

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows, no idling; config changes only where a row asks
    foreach (directed_rows[i]) begin
      apply_setting(directed_rows[i].gain, directed_rows[i].solid, 1'b0);
      send_pair(directed_rows[i].pair, directed_rows[i].known, directed_rows[i].want);
    end

    // random phases across gain extremes and both modes, idling rotates
    run_phase(PHASE_ITEMS, GAIN_RESET, 1'b0, 3);
    run_phase(PHASE_ITEMS, GAIN_RESET, 1'b1, 1);
    run_phase(PHASE_ITEMS, 15'd0, 1'b0, 2);
    run_phase(PHASE_ITEMS, 15'd32767, 1'b1, 3);
    run_phase(PHASE_ITEMS, 15'd25600, 1'b0, 0);
    run_phase(PHASE_ITEMS, 15'd128, 1'b0, 3);
    run_phase(PHASE_ITEMS, GAIN_W'($urandom_range(257, 25599)), 1'b1, 1);
    run_phase(PHASE_ITEMS, GAIN_W'($urandom), 1'b0, 2);

    // last stretch at full rate on both sides
    run_phase(FINAL_ITEMS, GAIN_W'($urandom_range(256, 25600)), 1'($urandom), 0);

    // collect everything, then stay idle to catch stray transactions
    drain_results();
    repeat (16) @(posedge clk);

    if (fail_count == 0)
      $display("** brightness_diff_overlay: PASSED **");
    else
      $display("** brightness_diff_overlay: FAILED **");
    $finish;
  end

endmodule
